// ===== rtl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, constants and the crc-16 byte update for the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam int          HDR_BYTES = 4;

    typedef enum logic [1:0] {
        ST_GOOD = 2'd0,
        ST_CRC  = 2'd1,
        ST_LEN  = 2'd2
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic    take;
        logic    load_single;
        t_status single_status;
        logic    rd_start;
        logic    rd_en;
        logic    load_data;
        logic    rd_next;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic hdr_len;
        logic len_too_big;
        logic crc_lo;
        logic crc_match;
        logic dest_match;
        logic len_zero;
        logic rd_last;
    } t_stat;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/serial_frame_receiver_crc16.sv =====
// ----------------------------------------------------------------------------
// serial_frame_receiver_crc16
// Frame receiver with crc-16 check (reflected poly 0xA001, init 0xFFFF).
// ----------------------------------------------------------------------------
// Bytes of a frame (destination, source, function, length, data, crc high,
// crc low) are taken one per cycle; the crc is updated in the same cycle.
// The length byte and the crc low byte are taken only when the result
// register is free or being emptied. A good frame addressed to the host
// address is then read out of the payload store one data byte at a time
// (store read, then result load, which waits out any output stall), and
// no byte is taken during that readout. Other outcomes give one result, or
// none for a good frame to another address. host_address resets to 0xFF.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_frame_receiver_crc16 #(
    parameter int MAX_DATA = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [7:0] i_cfg_wr_data,
    input  wire logic       i_rx_valid,
    output logic            o_rx_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_res_valid,
    input  wire logic       i_res_ready,
    output logic [1:0]      o_status,
    output logic [7:0]      o_source_address,
    output logic [7:0]      o_function_code,
    output logic [7:0]      o_data_length,
    output logic            o_has_data,
    output logic [4:0]      o_data_index,
    output logic [7:0]      o_data_byte,
    output logic            o_last
);
    import sfr_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    sfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    sfr_dp #(
        .MAX_DATA (MAX_DATA)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_rx_byte        (i_rx_byte),
        .i_res_ready      (i_res_ready),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_res_valid      (o_res_valid),
        .o_status         (o_status),
        .o_source_address (o_source_address),
        .o_function_code  (o_function_code),
        .o_data_length    (o_data_length),
        .o_has_data       (o_has_data),
        .o_data_index     (o_data_index),
        .o_data_byte      (o_data_byte),
        .o_last           (o_last)
    );

endmodule

`default_nettype wire

// ===== rtl/sfr_ram.sv =====
// ----------------------------------------------------------------------------
// sfr_ram
// Generic single write port, single read port ram with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                        i_wr_data,
    input  wire logic                                    i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/sfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfr_ctrl
// Controller: input handshake, result selection and payload readout sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rx_valid,
    output logic               o_rx_ready,
    input  wire sfr_pkg::t_stat i_stat,
    output sfr_pkg::t_cmd      o_cmd
);
    import sfr_pkg::*;

    typedef enum logic [2:0] {
        S_RECV = 3'b001,
        S_READ = 3'b010,
        S_LOAD = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_may_emit;
    logic   w_accept;

    assign w_may_emit = i_stat.hdr_len || i_stat.crc_lo;
    assign o_rx_ready = (r_state == S_RECV) && (i_stat.out_free || !w_may_emit);
    assign w_accept   = i_rx_valid && o_rx_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_RECV: begin
                if (w_accept) begin
                    o_cmd.take = 1'b1;
                    if (i_stat.hdr_len && i_stat.len_too_big) begin
                        o_cmd.load_single   = 1'b1;
                        o_cmd.single_status = ST_LEN;
                    end else if (i_stat.crc_lo) begin
                        if (!i_stat.crc_match) begin
                            o_cmd.load_single   = 1'b1;
                            o_cmd.single_status = ST_CRC;
                        end else if (i_stat.dest_match) begin
                            if (i_stat.len_zero) begin
                                o_cmd.load_single   = 1'b1;
                                o_cmd.single_status = ST_GOOD;
                            end else begin
                                o_cmd.rd_start = 1'b1;
                                n_state        = S_READ;
                            end
                        end
                    end
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_LOAD;
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.load_data = 1'b1;
                    if (i_stat.rd_last) begin
                        n_state = S_RECV;
                    end else begin
                        o_cmd.rd_next = 1'b1;
                        n_state       = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_RECV;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RECV;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sfr_dp.sv =====
// ----------------------------------------------------------------------------
// sfr_dp
// Datapath: byte position, crc, header fields, payload store and result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_dp #(
    parameter int MAX_DATA = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_wr_en,
    input  wire logic [7:0]     i_cfg_wr_data,
    input  wire logic [7:0]     i_rx_byte,
    input  wire logic           i_res_ready,
    input  wire sfr_pkg::t_cmd  i_cmd,
    output sfr_pkg::t_stat      o_stat,
    output logic                o_res_valid,
    output logic [1:0]          o_status,
    output logic [7:0]          o_source_address,
    output logic [7:0]          o_function_code,
    output logic [7:0]          o_data_length,
    output logic                o_has_data,
    output logic [4:0]          o_data_index,
    output logic [7:0]          o_data_byte,
    output logic                o_last
);
    import sfr_pkg::*;

    localparam int IW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
    localparam int PW = $clog2(MAX_DATA + 6);

    logic [7:0]    r_host_address;
    logic [PW-1:0] r_pos;
    logic [15:0]   r_crc;
    logic [7:0]    r_dest;
    logic [7:0]    r_source;
    logic [7:0]    r_function;
    logic [7:0]    r_length;
    logic [7:0]    r_crc_hi;
    logic [IW-1:0] r_rd_idx;

    logic          r_res_valid;
    t_status       r_status;
    logic [7:0]    r_res_source;
    logic [7:0]    r_res_function;
    logic [7:0]    r_res_length;
    logic          r_res_has;
    logic [4:0]    r_res_index;
    logic [7:0]    r_res_byte;
    logic          r_res_last;

    logic [8:0]    w_pos_ext;
    logic [8:0]    w_data_end;
    logic [8:0]    w_wr_off;
    logic          w_hdr;
    logic          w_data;
    logic          w_crc_hi;
    logic          w_crc_lo;
    logic          w_hdr_len;
    logic          w_too_big;
    logic          w_restart;
    logic          w_rd_last;
    logic          w_out_free;
    logic [7:0]    w_ram_data;

    assign w_pos_ext  = 9'(r_pos);
    assign w_data_end = 9'(r_length) + 9'(HDR_BYTES);
    assign w_wr_off   = w_pos_ext - 9'(HDR_BYTES);
    assign w_hdr      = r_pos < PW'(HDR_BYTES);
    assign w_data     = !w_hdr && (w_pos_ext < w_data_end);
    assign w_crc_hi   = !w_hdr && (w_pos_ext == w_data_end);
    assign w_crc_lo   = !w_hdr && !w_data && !w_crc_hi;
    assign w_hdr_len  = r_pos == PW'(HDR_BYTES - 1);
    assign w_too_big  = i_rx_byte > 8'(MAX_DATA);
    assign w_restart  = (w_hdr_len && w_too_big) || w_crc_lo;
    assign w_rd_last  = (8'(r_rd_idx) + 8'd1) == r_length;
    assign w_out_free = !r_res_valid || i_res_ready;

    always_comb begin
        o_stat             = '0;
        o_stat.out_free    = w_out_free;
        o_stat.hdr_len     = w_hdr_len;
        o_stat.len_too_big = w_too_big;
        o_stat.crc_lo      = w_crc_lo;
        o_stat.crc_match   = {r_crc_hi, i_rx_byte} == r_crc;
        o_stat.dest_match  = r_dest == r_host_address;
        o_stat.len_zero    = r_length == 8'd0;
        o_stat.rd_last     = w_rd_last;
    end

    sfr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_DATA)
    ) u_payload (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.take && w_data),
        .i_wr_addr (w_wr_off[IW-1:0]),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (w_ram_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_host_address <= 8'hFF;
            r_pos          <= '0;
            r_crc          <= CRC_INIT;
            r_res_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_host_address <= i_cfg_wr_data;
            end
            if (i_cmd.take) begin
                if (w_restart) begin
                    r_pos <= '0;
                    r_crc <= CRC_INIT;
                end else begin
                    r_pos <= r_pos + PW'(1);
                    if (w_hdr || w_data) begin
                        r_crc <= crc_feed(r_crc, i_rx_byte);
                    end
                end
            end
            if (i_cmd.load_single || i_cmd.load_data) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            if (w_hdr) begin
                case (r_pos[1:0])
                    2'd0:    r_dest     <= i_rx_byte;
                    2'd1:    r_source   <= i_rx_byte;
                    2'd2:    r_function <= i_rx_byte;
                    default: r_length   <= i_rx_byte;
                endcase
            end
            if (w_crc_hi) begin
                r_crc_hi <= i_rx_byte;
            end
        end
        if (i_cmd.rd_start) begin
            r_rd_idx <= '0;
        end else if (i_cmd.rd_next) begin
            r_rd_idx <= r_rd_idx + IW'(1);
        end
        if (i_cmd.load_single) begin
            r_status       <= i_cmd.single_status;
            r_res_source   <= r_source;
            r_res_function <= r_function;
            r_res_length   <= w_hdr_len ? i_rx_byte : r_length;
            r_res_has      <= 1'b0;
            r_res_index    <= '0;
            r_res_byte     <= '0;
            r_res_last     <= 1'b1;
        end else if (i_cmd.load_data) begin
            r_status       <= ST_GOOD;
            r_res_source   <= r_source;
            r_res_function <= r_function;
            r_res_length   <= r_length;
            r_res_has      <= 1'b1;
            r_res_index    <= 5'(r_rd_idx);
            r_res_byte     <= w_ram_data;
            r_res_last     <= w_rd_last;
        end
    end

    assign o_res_valid      = r_res_valid;
    assign o_status         = r_status;
    assign o_source_address = r_res_source;
    assign o_function_code  = r_res_function;
    assign o_data_length    = r_res_length;
    assign o_has_data       = r_res_has;
    assign o_data_index     = r_res_index;
    assign o_data_byte      = r_res_byte;
    assign o_last           = r_res_last;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the crc-16 frame receiver: frames are sent byte by
// byte over valid/ready, a byte-level model predicts each result transaction,
// and results are checked in order under varying idle patterns on both sides.
// ----------------------------------------------------------------------------
module tb;
    import sfr_pkg::*;

    localparam int MAX_DATA = 32;

    typedef struct packed {
        t_status    status;
        logic [7:0] src;
        logic [7:0] func;
        logic [7:0] len;
        logic       has_data;
        logic [4:0] idx;
        logic [7:0] data;
        logic       is_last;
    } t_frame_result;

    typedef enum logic [1:0] {
        FILL_RAND,
        FILL_ZERO,
        FILL_ONES,
        FILL_RAMP
    } t_fill;

    typedef struct {
        logic [7:0]    dest;
        logic [7:0]    src;
        logic [7:0]    func;
        logic [7:0]    len;
        t_fill         fill;
        logic          crc_err;
        logic          typed;
        t_frame_result want;
    } t_frame_row;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = 8'h00;
    logic       rx_valid    = 1'b0;
    logic [7:0] rx_byte     = 8'h00;
    logic       res_ready   = 1'b0;
    logic       hold_off    = 1'b0;
    logic       rx_ready;
    logic       res_valid;
    logic [1:0] res_status;
    logic [7:0] res_src;
    logic [7:0] res_func;
    logic [7:0] res_len;
    logic       res_has_data;
    logic [4:0] res_idx;
    logic [7:0] res_data;
    logic       res_last;

    int src_idle  = 15;
    int sink_idle = 83;
    int stage     = 0;
    int rx_count  = 0;
    int err_count = 0;

    // frame model state
    logic [7:0]  host_addr;
    int          frame_pos;
    logic [15:0] frame_crc;
    logic [7:0]  hdr_dest;
    logic [7:0]  hdr_src;
    logic [7:0]  hdr_func;
    logic [7:0]  hdr_len;
    logic [7:0]  crc_hi;
    logic [7:0]  payload [MAX_DATA];

    t_frame_result pending_results [$];
    t_frame_result typed_result;
    logic          typed_pending = 1'b0;
    t_frame_result seen;
    t_frame_result want;
    t_frame_row    dir_rows [6];

    serial_frame_receiver_crc16 #(
        .MAX_DATA(MAX_DATA)
    ) dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_wr_data    (cfg_wr_data),
        .i_rx_valid       (rx_valid),
        .o_rx_ready       (rx_ready),
        .i_rx_byte        (rx_byte),
        .o_res_valid      (res_valid),
        .i_res_ready      (res_ready),
        .o_status         (res_status),
        .o_source_address (res_src),
        .o_function_code  (res_func),
        .o_data_length    (res_len),
        .o_has_data       (res_has_data),
        .o_data_index     (res_idx),
        .o_data_byte      (res_data),
        .o_last           (res_last)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ b[k];
            c  = {1'b0, c[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic string fmt_result(input t_frame_result r);
        return $sformatf("st=%0d src=%h fn=%h len=%0d has=%b idx=%0d data=%h last=%b",
                         r.status, r.src, r.func, r.len, r.has_data, r.idx, r.data,
                         r.is_last);
    endfunction

    function automatic void push_result(input t_status st, input logic has,
                                        input logic [4:0] idx, input logic [7:0] d,
                                        input logic fin);
        t_frame_result r;
        r = '{st, hdr_src, hdr_func, hdr_len, has, idx, d, fin};
        if (typed_pending) begin
            pending_results.push_back(typed_result);
            typed_pending = 1'b0;
        end else begin
            pending_results.push_back(r);
        end
    endfunction

    function automatic void reset_frame_model();
        host_addr = 8'hFF;
        frame_pos = 0;
        frame_crc = CRC_INIT;
        hdr_dest  = 8'h00;
        hdr_src   = 8'h00;
        hdr_func  = 8'h00;
        hdr_len   = 8'h00;
        crc_hi    = 8'h00;
    endfunction

    function automatic void predict_frame_byte(input logic [7:0] b);
        if (frame_pos < HDR_BYTES) begin
            frame_crc = crc16_step(frame_crc, b);
            case (frame_pos)
                0: hdr_dest = b;
                1: hdr_src = b;
                2: hdr_func = b;
                default: hdr_len = b;
            endcase
            frame_pos++;
            if (frame_pos == HDR_BYTES && hdr_len > MAX_DATA) begin
                push_result(ST_LEN, 1'b0, 5'd0, 8'h00, 1'b1);
                frame_pos = 0;
                frame_crc = CRC_INIT;
            end
        end else if (frame_pos < HDR_BYTES + hdr_len) begin
            payload[frame_pos - HDR_BYTES] = b;
            frame_crc = crc16_step(frame_crc, b);
            frame_pos++;
        end else if (frame_pos == HDR_BYTES + hdr_len) begin
            crc_hi = b;
            frame_pos++;
        end else begin
            if ({crc_hi, b} != frame_crc) begin
                push_result(ST_CRC, 1'b0, 5'd0, 8'h00, 1'b1);
            end else if (hdr_dest == host_addr) begin
                if (hdr_len == 0) begin
                    push_result(ST_GOOD, 1'b0, 5'd0, 8'h00, 1'b1);
                end else begin
                    for (int i = 0; i < hdr_len; i++) begin
                        push_result(ST_GOOD, 1'b1, 5'(i), payload[i], (i + 1) == hdr_len);
                    end
                end
            end
            frame_pos = 0;
            frame_crc = CRC_INIT;
        end
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle && gap < 40) gap++;
        if (gap > 0) begin
            rx_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!rx_ready);
        predict_frame_byte(b);
        rx_count++;
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [7:0] dest, input logic [7:0] src,
                              input logic [7:0] func, input logic [7:0] len,
                              input t_fill fill, input logic crc_err);
        logic [7:0]  frame_bytes [$];
        logic [15:0] crc;
        logic [7:0]  d;
        frame_bytes = '{dest, src, func, len};
        if (len <= MAX_DATA) begin
            for (int i = 0; i < len; i++) begin
                case (fill)
                    FILL_ZERO: d = 8'h00;
                    FILL_ONES: d = 8'hFF;
                    FILL_RAMP: d = 8'(i);
                    default: d = 8'($urandom_range(255));
                endcase
                frame_bytes.push_back(d);
            end
            crc = CRC_INIT;
            foreach (frame_bytes[k]) crc = crc16_step(crc, frame_bytes[k]);
            if (crc_err) crc ^= 16'(1) << $urandom_range(15);
            frame_bytes.push_back(crc[15:8]);
            frame_bytes.push_back(crc[7:0]);
        end
        foreach (frame_bytes[k]) send_byte(frame_bytes[k]);
    endtask

    task automatic run_random_frames(input int budget);
        int         stop_at;
        int         pick;
        logic [7:0] len;
        logic [7:0] dest;
        stop_at = rx_count + budget;
        while (rx_count < stop_at) begin
            pick = $urandom_range(99);
            dest = ($urandom_range(99) < 75) ? host_addr : 8'($urandom_range(255));
            if (pick < 6) begin
                // broken sequence: stray bytes, then random bytes until resync
                repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)));
                while (frame_pos != 0) send_byte(8'($urandom_range(255)));
            end else if (pick < 12) begin
                send_frame(dest, 8'($urandom_range(255)), 8'($urandom_range(255)),
                           8'($urandom_range(255, MAX_DATA + 1)), FILL_RAND, 1'b0);
            end else begin
                pick = $urandom_range(99);
                if (pick < 55) begin
                    len = 8'($urandom_range(4, 0));
                end else if (pick < 85) begin
                    len = 8'($urandom_range(15, 5));
                end else if (pick < 95) begin
                    len = 8'($urandom_range(MAX_DATA - 1, 16));
                end else begin
                    len = 8'(MAX_DATA);
                end
                send_frame(dest, 8'($urandom_range(255)), 8'($urandom_range(255)), len,
                           FILL_RAND, $urandom_range(99) < 12);
            end
        end
    endtask

    task automatic drain_results(input int settle);
        int waited;
        rx_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 50000) begin
            @(negedge clk);
            waited++;
        end
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_host(input logic [7:0] a);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= a;
        @(posedge clk);
        host_addr = a;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    always @(negedge clk) begin
        res_ready <= !hold_off && ($urandom_range(99) >= sink_idle);
    end

    // long receiver hold-off so the block backs up and stalls its input
    initial begin
        wait (stage == 3);
        repeat (10) @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready) begin
            seen = '{t_status'(res_status), res_src, res_func, res_len, res_has_data,
                     res_idx, res_data, res_last};
            if (pending_results.size() == 0) begin
                if (err_count < 10) begin
                    $display("%0t: unexpected result transaction: %s", $realtime,
                             fmt_result(seen));
                end
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (want.status !== seen.status || want.src !== seen.src ||
                    want.func !== seen.func || want.len !== seen.len ||
                    want.has_data !== seen.has_data || want.idx !== seen.idx ||
                    want.data !== seen.data || want.is_last !== seen.is_last) begin
                    if (err_count < 10) begin
                        $display("%0t: mismatch", $realtime);
                        $display("  expected %s", fmt_result(want));
                        $display("  actual   %s", fmt_result(seen));
                    end
                    err_count++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("serial_frame_receiver_crc16 regression: fail");
        $finish;
    end

    initial begin
        reset_frame_model();
        dir_rows = '{
            '{8'hFF, 8'h00, 8'h00, 8'd0, FILL_ZERO, 1'b0, 1'b1,
              '{ST_GOOD, 8'h00, 8'h00, 8'd0, 1'b0, 5'd0, 8'h00, 1'b1}},
            '{8'hFF, 8'hFF, 8'hFF, 8'd33, FILL_ZERO, 1'b0, 1'b1,
              '{ST_LEN, 8'hFF, 8'hFF, 8'd33, 1'b0, 5'd0, 8'h00, 1'b1}},
            '{8'h00, 8'h12, 8'h34, 8'd255, FILL_ZERO, 1'b0, 1'b1,
              '{ST_LEN, 8'h12, 8'h34, 8'd255, 1'b0, 5'd0, 8'h00, 1'b1}},
            '{8'hFF, 8'hA5, 8'h5A, 8'd1, FILL_ZERO, 1'b1, 1'b1,
              '{ST_CRC, 8'hA5, 8'h5A, 8'd1, 1'b0, 5'd0, 8'h00, 1'b1}},
            '{8'h00, 8'h81, 8'h7E, 8'd0, FILL_ZERO, 1'b0, 1'b0, '0},
            '{8'hFF, 8'h3C, 8'hC3, 8'd2, FILL_ONES, 1'b0, 1'b0, '0}
        };
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed frames, host address still at its reset value
        foreach (dir_rows[i]) begin
            typed_result  = dir_rows[i].want;
            typed_pending = dir_rows[i].typed;
            send_frame(dir_rows[i].dest, dir_rows[i].src, dir_rows[i].func,
                       dir_rows[i].len, dir_rows[i].fill, dir_rows[i].crc_err);
        end
        typed_pending = 1'b0;
        drain_results(64);

        stage = 1;
        write_host(8'h00);
        run_random_frames(55);
        drain_results(64);

        stage     = 2;
        src_idle  = 83;
        sink_idle <= 15;
        write_host(8'($urandom_range(254, 1)));
        run_random_frames(55);
        drain_results(64);

        src_idle  = 0;
        sink_idle <= 0;
        write_host(8'hFF);
        stage = 3;
        run_random_frames(55);
        drain_results(80);

        if (pending_results.size() != 0) begin
            $display("%0d expected result transactions never arrived",
                     pending_results.size());
            err_count += pending_results.size();
        end
        if (err_count == 0) begin
            $display("serial_frame_receiver_crc16 regression: pass");
        end else begin
            $display("serial_frame_receiver_crc16 regression: fail");
        end
        $finish;
    end

endmodule
